@@ sv/prq_pkg.sv @@
package prq_pkg;

    localparam int NUM_PRIORITIES = 4;
    localparam int MAX_THREADS    = 64;

    // Field widths of the channel payloads
    localparam int TID_W = 6;
    localparam int LVL_W = 2;

    // Link memory addressing
    localparam int LINK_AW = $clog2(MAX_THREADS);

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_YIELD   = 1'b1;

    typedef logic [TID_W-1:0] t_tid;
    typedef logic [LVL_W-1:0] t_lvl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } t_state;

    function automatic t_lvl clamp_level(input logic [LVL_W-1:0] p);
        if (32'(p) >= NUM_PRIORITIES) begin
            return LVL_W'(NUM_PRIORITIES - 1);
        end
        return p;
    endfunction

    function automatic logic [LINK_AW-1:0] link_addr(input t_tid t);
        return t[LINK_AW-1:0];
    endfunction

endpackage

@@ sv/prq_ifs.sv @@
interface prq_req_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [prq_pkg::TID_W-1:0] thread_id;
    logic [prq_pkg::LVL_W-1:0] priority_req;
    logic                      current_exited;

    modport source (
        output valid, operation, thread_id, priority_req, current_exited,
        input  ready
    );
    modport sink (
        input  valid, operation, thread_id, priority_req, current_exited,
        output ready
    );
endinterface

interface prq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      switched;
    logic [prq_pkg::TID_W-1:0] next_thread_id;
    logic [prq_pkg::LVL_W-1:0] next_priority;

    modport source (
        output valid, switched, next_thread_id, next_priority,
        input  ready
    );
    modport sink (
        input  valid, switched, next_thread_id, next_priority,
        output ready
    );
endinterface

@@ sv/prq_link_ram.sv @@
module prq_link_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/priority_ready_queue_scheduler.sv @@
// Steps: an enqueue is done in the execute state after its transfer; a yield does
// search and link read, then pop and requeue; if nothing is found it ends there.
// One item at a time; an item waits in its last state while the result register
// is full and not taken, and the next item is taken while a result waits.
// Reset: synchronous active-low; thread 0 runs at priority 0, all queues empty.
// Link memory and queue head/tail hold no reset value.
module priority_ready_queue_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prq_req_if.sink     i_req,
    prq_rsp_if.source   o_rsp
);

    // Item registers
    prq_pkg::t_state r_state, n_state;
    logic            r_op;
    prq_pkg::t_tid   r_tid;
    prq_pkg::t_lvl   r_prio;
    logic            r_exited;

    // Queue table
    prq_pkg::t_tid   r_head [prq_pkg::NUM_PRIORITIES];
    prq_pkg::t_tid   n_head [prq_pkg::NUM_PRIORITIES];
    prq_pkg::t_tid   r_tail [prq_pkg::NUM_PRIORITIES];
    prq_pkg::t_tid   n_tail [prq_pkg::NUM_PRIORITIES];
    logic [prq_pkg::NUM_PRIORITIES-1:0] r_nonempty, n_nonempty;

    // Running thread
    prq_pkg::t_tid   r_run_tid, n_run_tid;
    prq_pkg::t_lvl   r_run_prio, n_run_prio;

    // Pop bookkeeping between search and pop
    prq_pkg::t_lvl   r_found, n_found;
    prq_pkg::t_tid   r_picked, n_picked;
    logic            r_last, n_last;

    // Output register
    logic            r_out_valid, n_out_valid;
    logic            r_out_sw, n_out_sw;
    prq_pkg::t_tid   r_out_tid, n_out_tid;
    prq_pkg::t_lvl   r_out_prio, n_out_prio;

    // Link memory port
    logic                         link_we, link_re;
    logic [prq_pkg::LINK_AW-1:0]  link_waddr, link_raddr;
    prq_pkg::t_tid                link_wdata, link_rdata;

    logic                         can_emit;
    logic                         found_any;
    prq_pkg::t_lvl                found_lvl;
    prq_pkg::t_lvl                min_lvl;
    prq_pkg::t_lvl                tail_lvl;
    prq_pkg::t_tid                tail_rd;
    prq_pkg::t_tid                head_rd;

    prq_link_ram #(
        .DEPTH (prq_pkg::MAX_THREADS),
        .WIDTH (prq_pkg::TID_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    assign i_req.ready          = (r_state == prq_pkg::S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.switched       = r_out_sw;
    assign o_rsp.next_thread_id = r_out_tid;
    assign o_rsp.next_priority  = r_out_prio;

    assign can_emit = !r_out_valid || o_rsp.ready;

    // Highest non-empty level at or above the search floor
    assign min_lvl = r_exited ? '0 : r_run_prio;

    always_comb begin
        found_any = 1'b0;
        found_lvl = '0;
        for (int i = 0; i < prq_pkg::NUM_PRIORITIES; i++) begin
            if (r_nonempty[i] && (prq_pkg::LVL_W'(i) >= min_lvl)) begin
                found_any = 1'b1;
                found_lvl = prq_pkg::LVL_W'(i);
            end
        end
    end

    // Single read select on each of the head and tail tables
    always_comb begin
        case (r_state)
            prq_pkg::S_POP:  tail_lvl = r_run_prio;
            prq_pkg::S_EXEC: tail_lvl = (r_op == prq_pkg::OP_ENQUEUE) ? r_prio : found_lvl;
            default:         tail_lvl = r_prio;
        endcase
    end

    assign tail_rd = r_tail[tail_lvl];
    assign head_rd = r_head[found_lvl];

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_nonempty  = r_nonempty;
        n_run_tid   = r_run_tid;
        n_run_prio  = r_run_prio;
        n_found     = r_found;
        n_picked    = r_picked;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_sw    = r_out_sw;
        n_out_tid   = r_out_tid;
        n_out_prio  = r_out_prio;
        link_we     = 1'b0;
        link_waddr  = prq_pkg::link_addr(tail_rd);
        link_wdata  = r_tid;
        link_re     = 1'b0;
        link_raddr  = prq_pkg::link_addr(head_rd);

        case (r_state)
            prq_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = prq_pkg::S_EXEC;
                end
            end

            prq_pkg::S_EXEC: begin
                if (r_op == prq_pkg::OP_ENQUEUE) begin
                    if (can_emit) begin
                        if (r_nonempty[r_prio]) begin
                            link_we = 1'b1;
                        end else begin
                            n_head[r_prio]     = r_tid;
                            n_nonempty[r_prio] = 1'b1;
                        end
                        n_tail[r_prio] = r_tid;
                        n_out_valid    = 1'b1;
                        n_out_sw       = 1'b0;
                        n_out_tid      = r_run_tid;
                        n_out_prio     = r_run_prio;
                        n_state        = prq_pkg::S_IDLE;
                    end
                end else if (!found_any) begin
                    if (can_emit) begin
                        n_out_valid = 1'b1;
                        n_out_sw    = 1'b0;
                        n_out_tid   = r_run_tid;
                        n_out_prio  = r_run_prio;
                        n_state     = prq_pkg::S_IDLE;
                    end
                end else begin
                    // Fetch the successor of the picked head
                    link_re  = 1'b1;
                    n_found  = found_lvl;
                    n_picked = head_rd;
                    n_last   = (head_rd == tail_rd);
                    n_state  = prq_pkg::S_POP;
                end
            end

            prq_pkg::S_POP: begin
                if (can_emit) begin
                    if (r_last) begin
                        n_nonempty[r_found] = 1'b0;
                    end else begin
                        n_head[r_found] = link_rdata;
                    end
                    // Requeue the running thread, seeing the queue as left by the pop
                    if (!r_exited) begin
                        if (n_nonempty[r_run_prio]) begin
                            link_we    = 1'b1;
                            link_wdata = r_run_tid;
                        end else begin
                            n_head[r_run_prio]     = r_run_tid;
                            n_nonempty[r_run_prio] = 1'b1;
                        end
                        n_tail[r_run_prio] = r_run_tid;
                    end
                    n_run_tid   = r_picked;
                    n_run_prio  = r_found;
                    n_out_valid = 1'b1;
                    n_out_sw    = 1'b1;
                    n_out_tid   = r_picked;
                    n_out_prio  = r_found;
                    n_state     = prq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = prq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prq_pkg::S_IDLE;
            r_nonempty  <= '0;
            r_run_tid   <= '0;
            r_run_prio  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nonempty  <= n_nonempty;
            r_run_tid   <= n_run_tid;
            r_run_prio  <= n_run_prio;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op     <= i_req.operation;
            r_tid    <= i_req.thread_id;
            r_prio   <= prq_pkg::clamp_level(i_req.priority_req);
            r_exited <= i_req.current_exited;
        end
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_found    <= n_found;
        r_picked   <= n_picked;
        r_last     <= n_last;
        r_out_sw   <= n_out_sw;
        r_out_tid  <= n_out_tid;
        r_out_prio <= n_out_prio;
    end

endmodule

@@ verif/priority_ready_queue_scheduler_tb.sv @@
`timescale 1ns / 100ps

module priority_ready_queue_scheduler_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic          switched;
        prq_pkg::t_tid tid;
        prq_pkg::t_lvl lvl;
    } t_run_state;

    logic i_clk;
    logic i_rst_n;

    prq_req_if req_if ();
    prq_rsp_if rsp_if ();

    priority_ready_queue_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Scheduler state as predicted from the accepted items
    prq_pkg::t_tid q_head [prq_pkg::NUM_PRIORITIES];
    prq_pkg::t_tid q_tail [prq_pkg::NUM_PRIORITIES];
    logic          q_busy [prq_pkg::NUM_PRIORITIES];
    prq_pkg::t_tid link_mem [prq_pkg::MAX_THREADS];
    bit            link_set [prq_pkg::MAX_THREADS];
    int unsigned   queued_cnt [prq_pkg::MAX_THREADS];
    prq_pkg::t_tid run_tid;
    prq_pkg::t_lvl run_lvl;

    t_run_state  expected_running [$];

    int unsigned errors;
    int unsigned n_items;
    int unsigned n_enqueues;
    int unsigned n_yields;
    int unsigned n_switches;
    int unsigned n_dups;
    int unsigned n_results;
    int unsigned idle_cycles;
    bit          req_gaps;
    bit          rsp_gaps;
    int          hold_request;

    function automatic prq_pkg::t_lvl saturate_level(logic [prq_pkg::LVL_W-1:0] p);
        return (int'(p) >= prq_pkg::NUM_PRIORITIES) ?
               prq_pkg::t_lvl'(prq_pkg::NUM_PRIORITIES - 1) : prq_pkg::t_lvl'(p);
    endfunction

    function automatic prq_pkg::t_tid wrap_thread(prq_pkg::t_tid t);
        return prq_pkg::t_tid'(int'(t) % prq_pkg::MAX_THREADS);
    endfunction

    function automatic void push_thread(prq_pkg::t_tid t, prq_pkg::t_lvl lvl);
        prq_pkg::t_tid ti;
        prq_pkg::t_lvl li;
        ti = wrap_thread(t);
        li = saturate_level(lvl);
        if (q_busy[li]) begin
            link_mem[wrap_thread(q_tail[li])] = ti;
            link_set[wrap_thread(q_tail[li])] = 1'b1;
            q_tail[li] = ti;
        end else begin
            q_head[li] = ti;
            q_tail[li] = ti;
            q_busy[li] = 1'b1;
        end
        queued_cnt[ti]++;
    endfunction

    // Highest non-empty level a yield may take from, or -1
    function automatic int find_level(logic exited);
        int floor_lvl;
        floor_lvl = exited ? 0 : int'(saturate_level(run_lvl));
        for (int l = prq_pkg::NUM_PRIORITIES - 1; l >= floor_lvl; l--) begin
            if (q_busy[l]) return l;
        end
        return -1;
    endfunction

    // Level whose pop would follow a link that was never written, or -1
    function automatic int blocked_level(logic exited);
        int            f;
        prq_pkg::t_tid h;
        f = find_level(exited);
        if (f < 0) return -1;
        h = wrap_thread(q_head[f]);
        if (h != wrap_thread(q_tail[f]) && !link_set[h]) return f;
        return -1;
    endfunction

    function automatic t_run_state advance_scheduler(logic op, prq_pkg::t_tid tid,
                                                     prq_pkg::t_lvl prio, logic exited);
        t_run_state    r;
        int            f;
        prq_pkg::t_tid picked;
        r.switched = 1'b0;
        if (op == prq_pkg::OP_ENQUEUE) begin
            push_thread(tid, prio);
        end else begin
            f = find_level(exited);
            if (f >= 0) begin
                picked = wrap_thread(q_head[f]);
                if (picked == wrap_thread(q_tail[f])) begin
                    q_busy[f] = 1'b0;
                end else begin
                    q_head[f] = link_mem[picked];
                end
                if (queued_cnt[picked] > 0) queued_cnt[picked]--;
                if (!exited) push_thread(run_tid, run_lvl);
                run_tid    = picked;
                run_lvl    = prq_pkg::t_lvl'(f);
                r.switched = 1'b1;
            end
        end
        r.tid = run_tid;
        r.lvl = run_lvl;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic send_item(logic op, prq_pkg::t_tid tid, prq_pkg::t_lvl prio,
                             logic exited);
        t_run_state r;
        if (req_gaps && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.operation      <= op;
        req_if.thread_id      <= tid;
        req_if.priority_req   <= prio;
        req_if.current_exited <= exited;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        n_items++;
        if (op == prq_pkg::OP_ENQUEUE) begin
            n_enqueues++;
            if (queued_cnt[wrap_thread(tid)] > 0 || wrap_thread(tid) == run_tid) n_dups++;
        end else begin
            n_yields++;
        end
        r = advance_scheduler(op, tid, prio, exited);
        if (r.switched) n_switches++;
        expected_running.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        logic          op;
        logic          exited;
        prq_pkg::t_tid tid;
        prq_pkg::t_lvl prio;
        int            f;
        int            free_list [$];
        op     = ($urandom_range(0, 99) < 48) ? prq_pkg::OP_YIELD : prq_pkg::OP_ENQUEUE;
        tid    = prq_pkg::t_tid'($urandom);
        prio   = prq_pkg::t_lvl'($urandom);
        exited = ($urandom_range(0, 3) == 0);
        // Mostly enqueue threads that are neither queued nor running
        if (op == prq_pkg::OP_ENQUEUE && $urandom_range(0, 15) != 0) begin
            for (int t = 0; t < prq_pkg::MAX_THREADS; t++) begin
                if (queued_cnt[t] == 0 && prq_pkg::t_tid'(t) != run_tid)
                    free_list.push_back(t);
            end
            if (free_list.size() == 0) begin
                op = prq_pkg::OP_YIELD;
            end else begin
                tid = prq_pkg::t_tid'(free_list[$urandom_range(0, free_list.size() - 1)]);
            end
        end
        // Requeue a stuck head at its own level so the next pop ends that list cleanly
        if (op == prq_pkg::OP_YIELD) begin
            f = blocked_level(exited);
            if (f >= 0) begin
                op   = prq_pkg::OP_ENQUEUE;
                tid  = q_head[f];
                prio = prq_pkg::t_lvl'(f);
            end
        end
        send_item(op, tid, prio, exited);
    endtask

    task automatic stop_sending();
        req_if.valid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (expected_running.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_empty_yields();
        send_item(prq_pkg::OP_YIELD, 6'd63, 2'd3, 1'b0);
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b1);
        stop_sending();
    endtask

    task automatic test_priority_order();
        send_item(prq_pkg::OP_ENQUEUE, 6'd63, 2'd3, 1'b1);
        send_item(prq_pkg::OP_ENQUEUE, 6'd1, 2'd0, 1'b0);
        send_item(prq_pkg::OP_ENQUEUE, 6'd2, 2'd0, 1'b1);
        send_item(prq_pkg::OP_ENQUEUE, 6'd5, 2'd2, 1'b0);
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b0);    // take 63, requeue idle thread 0
        send_item(prq_pkg::OP_YIELD, 6'd21, 2'd1, 1'b0);   // nothing at or above level 3
        send_item(prq_pkg::OP_YIELD, 6'd42, 2'd2, 1'b1);   // exited: drop 63, take 5
        send_item(prq_pkg::OP_ENQUEUE, 6'd40, 2'd1, 1'b0);
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd3, 1'b0);    // level 1 is below the runner
        send_item(prq_pkg::OP_YIELD, 6'd63, 2'd0, 1'b1);
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b0);    // own level empty: no switch
        send_item(prq_pkg::OP_ENQUEUE, 6'd7, 2'd1, 1'b1);
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b0);    // round robin within level 1
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b0);
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b1);
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b1);    // fall back to the idle level
        stop_sending();
    endtask

    task automatic test_duplicate_enqueue();
        send_item(prq_pkg::OP_ENQUEUE, 6'd2, 2'd3, 1'b0);  // 2 is already queued at level 0
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b0);
        send_item(prq_pkg::OP_ENQUEUE, 6'd0, 2'd2, 1'b0);  // 0 sits mid-list at level 0
        send_item(prq_pkg::OP_ENQUEUE, 6'd9, 2'd2, 1'b0);  // overwrites the link of thread 0
        send_item(prq_pkg::OP_ENQUEUE, 6'd1, 2'd2, 1'b0);
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b1);
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b1);
        send_item(prq_pkg::OP_YIELD, 6'd0, 2'd0, 1'b0);
        stop_sending();
    endtask

    task automatic test_output_backpressure();
        req_gaps     = 1'b0;
        hold_request = 150;
        repeat (24) send_random_item();
        stop_sending();
        req_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 500; i++) begin
            send_random_item();
            if (i % 60 == 59) begin
                stop_sending();
                wait_until_drained();
            end
        end
        stop_sending();
    endtask

    task automatic test_back_to_back();
        req_gaps = 1'b0;
        rsp_gaps = 1'b0;
        repeat (80) send_random_item();
        stop_sending();
    endtask

    // Result side: random stalls, plus one long hold on request
    initial begin : rsp_driver
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && rsp_gaps && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_run_state want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            n_results++;
            if (expected_running.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                          n_results));
            end else begin
                want = expected_running.pop_front();
                if (rsp_if.switched !== want.switched)
                    report_mismatch($sformatf("result %0d: switched %b, expected %b",
                                              n_results, rsp_if.switched, want.switched));
                if (rsp_if.next_thread_id !== want.tid)
                    report_mismatch($sformatf("result %0d: next_thread_id %0d, expected %0d",
                                              n_results, rsp_if.next_thread_id, want.tid));
                if (rsp_if.next_priority !== want.lvl)
                    report_mismatch($sformatf("result %0d: next_priority %0d, expected %0d",
                                              n_results, rsp_if.next_priority, want.lvl));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_running.size());
            $display("priority_ready_queue_scheduler_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.operation      = prq_pkg::OP_ENQUEUE;
        req_if.thread_id      = '0;
        req_if.priority_req   = '0;
        req_if.current_exited = 1'b0;
        errors       = 0;
        n_items      = 0;
        n_enqueues   = 0;
        n_yields     = 0;
        n_switches   = 0;
        n_dups       = 0;
        n_results    = 0;
        idle_cycles  = 0;
        hold_request = 0;
        req_gaps     = 1'b1;
        rsp_gaps     = 1'b1;
        run_tid      = '0;
        run_lvl      = '0;
        for (int l = 0; l < prq_pkg::NUM_PRIORITIES; l++) begin
            q_head[l] = '0;
            q_tail[l] = '0;
            q_busy[l] = 1'b0;
        end
        for (int t = 0; t < prq_pkg::MAX_THREADS; t++) begin
            link_mem[t]   = '0;
            link_set[t]   = 1'b0;
            queued_cnt[t] = 0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_yields();
        wait_until_drained();
        test_priority_order();
        wait_until_drained();
        test_duplicate_enqueue();
        wait_until_drained();
        test_output_backpressure();
        wait_until_drained();
        test_random_traffic();
        wait_until_drained();
        test_back_to_back();
        wait_until_drained();

        $display("run covered %0d items (%0d enqueues, %0d of them duplicates, %0d yields)",
                 n_items, n_enqueues, n_dups, n_yields);
        $display("%0d yields switched threads, %0d results checked, %0d mismatches",
                 n_switches, n_results, errors);
        if (errors == 0) begin
            $display("priority_ready_queue_scheduler_tb OK");
        end else begin
            $display("priority_ready_queue_scheduler_tb NOT OK");
        end
        $finish;
    end

endmodule
